[rtl/kvs_pkg.sv]
`default_nettype none

package kvs_pkg;

    // One input beat: a key load or a sample request
    typedef struct packed {
        logic               op;
        logic [3:0]         key_index;
        logic [31:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]        query_time;
    } t_item;

    // One result beat
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } t_res;

    // One word of the key table: time and value of one key
    typedef struct packed {
        logic [31:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_STORED = 2'd1;
    localparam logic [1:0] STAT_PAST   = 2'd2;

    // Register indexes (paddr bit 2)
    localparam logic REG_KEYS  = 1'b0;
    localparam logic REG_CLAMP = 1'b1;

    // Q16.16 one, and quotient bits of the factor divide
    localparam logic signed [31:0] FACTOR_ONE = 32'sd65536;
    localparam int                 DIV_STEPS  = 48;

endpackage

`default_nettype wire

[rtl/kvs_ram.sv]
`default_nettype none

module kvs_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/keyframe_vec3_sampler.sv]
`default_nettype none

// Keyframe table with linear interpolation of a three-component Q16.16 value.
// Input channel: an item is taken when start is high and busy is low. A load
// item (op 0) writes one key into the table in the cycle it is taken and does
// not raise busy, so loads can follow every cycle. A sample item (op 1) raises
// busy until its result is out.
// Result channel: o_res is valid for exactly one cycle, marked by o_res_valid,
// and cannot be held off. The next item is taken while that beat shows.
// Sequence: a load returns its stored beat from the taking edge; a sample with
// one key in use reads key 0 (S_ONE); a sample past the last key returns after
// the scan; an interpolated sample scans, fetches the start key (S_LDA),
// divides (S_DIV), forms the factor (S_FAC) and mixes (S_MUL, S_ACC).
// The table is one memory word per key, read once per cycle: the scan reads
// one key per cycle, the factor comes from a restoring divider that resolves
// one quotient bit per cycle, and a single 32x32 multiplier mixes the three
// components one after another (a multiply and an accumulate step each).
// Configuration over the APB port: keys_in_use at 0x0, clamp_factor at 0x4.
// The user writes them only while the block is idle; the block does not enforce
// this. Reset sets keys_in_use to 1, clears clamp_factor and returns to idle; the
// key table is not cleared and must be loaded before it is sampled.
module keyframe_vec3_sampler #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire kvs_pkg::t_item i_item,
    output logic                o_res_valid,
    output kvs_pkg::t_res       o_res,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    import kvs_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ONE  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LDA  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FAC  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_ACC  = 3'd7;

    // Control and configuration
    logic [2:0]          r_state;
    logic                r_valid;
    logic [4:0]          r_kiu;
    logic                r_clamp;
    logic [AW-1:0]       r_idx;
    logic [5:0]          r_cnt;
    logic [1:0]          r_k;

    // Datapath
    logic [31:0]         r_qt;
    logic [31:0]         r_t1;
    logic [31:0]         r_den;
    logic                r_neg;
    logic [31:0]         r_rem;
    logic [47:0]         r_dq;
    logic signed [31:0]  r_f;
    logic [2:0][31:0]    r_av;
    logic [2:0][31:0]    r_bv;
    logic [2:0][31:0]    r_ov;
    logic [31:0]         r_acur;
    logic [63:0]         r_prod;
    logic                r_pneg;
    t_res                r_res;

    // Memory ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;
    t_key                wr_key;
    t_key                rd_key;

    logic                take;
    logic                cfg_wr;
    logic [CW-1:0]       keys_eff;
    logic                one_key;
    logic                scan_hit;
    logic                scan_last;

    // Divider step
    logic [32:0]         div_sh;
    logic [33:0]         div_diff;
    logic                div_ge;

    // Factor saturation and clamp
    logic                q_big;
    logic signed [31:0]  f_raw;
    logic signed [31:0]  f_fin;

    // Mix
    logic [32:0]         mix_d;
    logic [32:0]         mix_dn;
    logic [31:0]         mix_dm;
    logic [31:0]         mix_fm;
    logic [63:0]         mix_rnd;
    logic [49:0]         mix_step;
    logic [49:0]         mix_sum;
    logic [31:0]         mix_sat;

    assign take   = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_KEYS:  prdata = {27'd0, r_kiu};
            REG_CLAMP: prdata = {31'd0, r_clamp};
        endcase
    end

    // Effective key count: zero acts as one, beyond the table acts as full
    always_comb begin
        if (r_kiu == 5'd0) begin
            keys_eff = CW'(1);
        end else if (32'(r_kiu) > MAX_KEYS) begin
            keys_eff = CW'(MAX_KEYS);
        end else begin
            keys_eff = CW'(r_kiu);
        end
    end
    assign one_key = (keys_eff == CW'(1));

    // Key table
    assign wr_key.key_time = i_item.key_time;
    assign wr_key.key_x    = i_item.key_x;
    assign wr_key.key_y    = i_item.key_y;
    assign wr_key.key_z    = i_item.key_z;
    assign ram_we    = take && (i_item.op == OP_LOAD) && (32'(i_item.key_index) < MAX_KEYS);
    assign ram_waddr = AW'(i_item.key_index);
    assign rd_key    = ram_rdata;

    kvs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Scan: the word in hand is key r_idx, the end key of segment r_idx-1
    assign scan_hit  = (r_qt < rd_key.key_time);
    assign scan_last = (CW'(r_idx) == keys_eff - CW'(1));

    // Read address: first probe on take, then walk ahead or step back to the start key
    always_comb begin
        ram_raddr = '0;
        if (r_state == S_IDLE) begin
            ram_raddr = one_key ? AW'(0) : AW'(1);
        end else if (r_state == S_SCAN) begin
            ram_raddr = scan_hit ? (r_idx - AW'(1)) : (r_idx + AW'(1));
        end
    end

    // Restoring divide, one quotient bit per cycle
    assign div_sh   = {r_rem, r_dq[47]};
    assign div_diff = {1'b0, div_sh} - {2'b00, r_den};
    assign div_ge   = !div_diff[33];

    // Saturate the quotient to signed Q16.16, then clamp to zero..one if asked
    assign q_big = |r_dq[47:31];
    always_comb begin
        if (r_neg) begin
            f_raw = q_big ? 32'sh8000_0000 : -$signed({1'b0, r_dq[30:0]});
        end else begin
            f_raw = q_big ? 32'sh7FFF_FFFF : $signed({1'b0, r_dq[30:0]});
        end
        f_fin = f_raw;
        if (r_clamp) begin
            if (f_raw < 0) begin
                f_fin = '0;
            end else if (f_raw > FACTOR_ONE) begin
                f_fin = FACTOR_ONE;
            end
        end
    end

    // Mix, multiply half: magnitudes of difference and factor
    assign mix_d  = {r_bv[0][31], r_bv[0]} - {r_av[0][31], r_av[0]};
    assign mix_dn = -mix_d;
    assign mix_dm = mix_d[32] ? mix_dn[31:0] : mix_d[31:0];
    assign mix_fm = r_f[31] ? (32'd0 - r_f) : r_f;

    // Mix, accumulate half: round half away from zero, add, saturate
    assign mix_rnd  = r_prod + 64'd32768;
    assign mix_step = r_pneg ? (50'd0 - {2'b00, mix_rnd[63:16]}) : {2'b00, mix_rnd[63:16]};
    assign mix_sum  = {{18{r_acur[31]}}, r_acur} + mix_step;
    always_comb begin
        if ((&mix_sum[49:31]) || !(|mix_sum[49:31])) begin
            mix_sat = mix_sum[31:0];
        end else begin
            mix_sat = mix_sum[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_kiu   <= 5'd1;
            r_clamp <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            // Configuration writes
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_KEYS:  r_kiu   <= pwdata[4:0];
                    REG_CLAMP: r_clamp <= pwdata[0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_qt <= i_item.query_time;
                        if (i_item.op == OP_LOAD) begin
                            r_res.out_x  <= '0;
                            r_res.out_y  <= '0;
                            r_res.out_z  <= '0;
                            r_res.status <= STAT_STORED;
                            r_valid      <= 1'b1;
                        end else if (one_key) begin
                            r_state <= S_ONE;
                        end else begin
                            r_idx   <= AW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_ONE: begin
                    r_res.out_x  <= rd_key.key_x;
                    r_res.out_y  <= rd_key.key_y;
                    r_res.out_z  <= rd_key.key_z;
                    r_res.status <= STAT_OK;
                    r_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end

                S_SCAN: begin
                    if (scan_hit) begin
                        // hold the end key, fetch the start key
                        r_t1    <= rd_key.key_time;
                        r_bv    <= {rd_key.key_z, rd_key.key_y, rd_key.key_x};
                        r_state <= S_LDA;
                    end else if (scan_last) begin
                        r_res.out_x  <= '0;
                        r_res.out_y  <= '0;
                        r_res.out_z  <= '0;
                        r_res.status <= STAT_PAST;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end

                S_LDA: begin
                    r_av <= {rd_key.key_z, rd_key.key_y, rd_key.key_x};
                    r_k  <= 2'd0;
                    if (r_t1 > rd_key.key_time) begin
                        // start the factor divide on |t - t0| << 16 over t1 - t0
                        r_neg   <= (r_qt < rd_key.key_time);
                        r_dq    <= (r_qt < rd_key.key_time)
                                   ? {rd_key.key_time - r_qt, 16'd0}
                                   : {r_qt - rd_key.key_time, 16'd0};
                        r_den   <= r_t1 - rd_key.key_time;
                        r_rem   <= '0;
                        r_cnt   <= 6'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end else begin
                        // end key not later than the start key: stay on the start key
                        r_f     <= '0;
                        r_state <= S_MUL;
                    end
                end

                S_DIV: begin
                    r_rem <= div_ge ? div_diff[31:0] : div_sh[31:0];
                    r_dq  <= {r_dq[46:0], div_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_FAC;
                    end
                end

                S_FAC: begin
                    r_f     <= f_fin;
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    r_prod  <= 64'(mix_dm) * 64'(mix_fm);
                    r_pneg  <= mix_d[32] ^ r_f[31];
                    r_acur  <= r_av[0];
                    r_av    <= {r_av[0], r_av[2:1]};
                    r_bv    <= {r_bv[0], r_bv[2:1]};
                    r_state <= S_ACC;
                end

                S_ACC: begin
                    r_ov <= {mix_sat, r_ov[2:1]};
                    r_k  <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_res.out_x  <= r_ov[1];
                        r_res.out_y  <= r_ov[2];
                        r_res.out_z  <= mix_sat;
                        r_res.status <= STAT_OK;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
            endcase
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[dv/keyframe_vec3_sampler_tb.sv]
`timescale 1ns / 1ps

module keyframe_vec3_sampler_tb;

    import kvs_pkg::*;

    localparam int MAX_KEYS    = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;
    localparam int RUN_LIMIT   = 5_000_000;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    t_item       i_item   = '0;
    logic        o_res_valid;
    t_res        o_res;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Items waiting to be driven, and the poses expected back in order
    t_item pending_items[$];
    t_res  expected_poses[$];

    // Predicted key table and register copies
    logic        [31:0] time_mem[MAX_KEYS];
    logic signed [31:0] x_mem[MAX_KEYS];
    logic signed [31:0] y_mem[MAX_KEYS];
    logic signed [31:0] z_mem[MAX_KEYS];
    logic        [4:0]  cfg_keys  = 5'd1;
    logic               cfg_clamp = 1'b0;

    // Key times as the stimulus plans them, ahead of the block
    logic [31:0] plan_time[MAX_KEYS];

    int phase_keys[PHASES]  = '{16, 31, 2, 1, 5, 9, 16, 3};
    int phase_clamp[PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0};

    logic took        = 1'b0;
    int   gap_left    = 0;
    int   steady_left = 0;
    int   gap_roll;
    t_res want_res;

    int mismatch_count  = 0;
    int checked_count   = 0;
    int loads_taken     = 0;
    int samples_taken   = 0;
    int clamped_samples = 0;
    int past_seen       = 0;

    keyframe_vec3_sampler #(
        .MAX_KEYS(MAX_KEYS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_res_valid(o_res_valid),
        .o_res(o_res),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat_q16(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 factor: truncating divide, magnitude held to 2^31 then saturated
    function automatic longint factor_q16(input longint num, input logic [63:0] den);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        longint      f;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag << 16) / den;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        f = neg ? -$signed(q) : $signed(q);
        return sat_q16(f);
    endfunction

    // a + (b - a) * f, step rounded half away from zero, sum saturated
    function automatic longint blend(input logic signed [31:0] a_raw,
                                     input logic signed [31:0] b_raw,
                                     input longint f);
        longint      a;
        longint      d;
        longint      step;
        logic        neg;
        logic [63:0] dm;
        logic [63:0] fm;
        logic [63:0] q;
        a = a_raw;
        d = b_raw;
        d = d - a;
        neg = (d < 0) != (f < 0);
        dm = (d < 0) ? -d : d;
        fm = (f < 0) ? -f : f;
        q = (dm * fm + 64'd32768) >> 16;
        step = neg ? -$signed(q) : $signed(q);
        return sat_q16(a + step);
    endfunction

    function automatic int keys_active();
        if (cfg_keys < 1) return 1;
        if (cfg_keys > MAX_KEYS) return MAX_KEYS;
        return int'(cfg_keys);
    endfunction

    // Apply one item to the predicted table and work out its pose
    function automatic t_res track_step(input t_item it);
        t_res        r;
        int          n;
        int          seg;
        logic        found;
        longint      f;
        logic [31:0] t0;
        logic [31:0] t1;
        longint      num;
        r = '0;
        if (it.op == OP_LOAD) begin
            time_mem[it.key_index] = it.key_time;
            x_mem[it.key_index] = it.key_x;
            y_mem[it.key_index] = it.key_y;
            z_mem[it.key_index] = it.key_z;
            r.status = STAT_STORED;
            return r;
        end
        n = keys_active();
        if (n == 1) begin
            r.out_x = x_mem[0];
            r.out_y = y_mem[0];
            r.out_z = z_mem[0];
            r.status = STAT_OK;
            return r;
        end
        // find the first segment whose end key lies beyond the query
        found = 1'b0;
        seg = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (!found && it.query_time < time_mem[i + 1]) begin
                seg = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            r.status = STAT_PAST;
            return r;
        end
        t0 = time_mem[seg];
        t1 = time_mem[seg + 1];
        if (t1 <= t0) begin
            f = 0;
        end else begin
            num = $signed({32'd0, it.query_time}) - $signed({32'd0, t0});
            f = factor_q16(num, {32'd0, t1 - t0});
        end
        if (cfg_clamp) begin
            if (f < 0) f = 0;
            if (f > 65536) f = 65536;
        end
        r.out_x = 32'(blend(x_mem[seg], x_mem[seg + 1], f));
        r.out_y = 32'(blend(y_mem[seg], y_mem[seg + 1], f));
        r.out_z = 32'(blend(z_mem[seg], z_mem[seg + 1], f));
        r.status = STAT_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Key value: extremes, small values around zero, or anything
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_load(input int slot, input logic [31:0] t,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] vz);
        t_item it;
        it.op = OP_LOAD;
        it.key_index = 4'(slot);
        it.key_time = t;
        it.key_x = vx;
        it.key_y = vy;
        it.key_z = vz;
        it.query_time = $urandom;
        plan_time[slot] = t;
        pending_items = {pending_items, it};
    endtask

    // Sample beat; key fields carry noise the block must ignore
    task automatic queue_sample(input logic [31:0] qt);
        t_item it;
        it.op = OP_SAMPLE;
        it.key_index = 4'($urandom);
        it.key_time = $urandom;
        it.key_x = $urandom;
        it.key_y = $urandom;
        it.key_z = $urandom;
        it.query_time = qt;
        pending_items = {pending_items, it};
    endtask

    // Load slots 0..n-1 with ascending times; the top of the range saturates
    task automatic fill_track(input int n, input int scale);
        logic [63:0] acc;
        acc = 64'($urandom) >> $urandom_range(0, 31);
        for (int i = 0; i < n; i++) begin
            acc = acc + 1 + (64'($urandom) & ((64'd1 << scale) - 1));
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            queue_load(i, acc[31:0], rand_value(), rand_value(), rand_value());
        end
    endtask

    // Query time: half the time inside a segment, else on a key, past or before the track, or random
    function automatic logic [31:0] pick_query(input int n);
        int          s;
        logic [31:0] lo;
        logic [31:0] hi;
        if (n < 2) return $urandom;
        s = $urandom_range(0, n - 2);
        lo = plan_time[s];
        hi = plan_time[s + 1];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
            5: return lo;
            6: return plan_time[n - 1] + $urandom_range(0, 3);
            7: return (plan_time[0] == 0) ? 32'd0 : $urandom_range(0, plan_time[0] - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_sel == REG_KEYS) cfg_keys = value[4:0];
        else cfg_clamp = value[0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold off until every queued item has gone in and every pose has come back
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_poses.size() != 0 || start)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Note the edges at which the block takes a beat
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
    end

    // Drive beats at the falling edge; predict each one taken
    always @(negedge i_clk) begin
        if (took) begin
            if (pending_items[0].op == OP_LOAD) begin
                loads_taken++;
            end else begin
                samples_taken++;
                if (cfg_clamp) clamped_samples++;
            end
            expected_poses = {expected_poses, track_step(pending_items.pop_front())};
            // pick the next gap: mostly none, some short, a few long
            gap_roll = $urandom_range(0, 99);
            if (steady_left != 0) begin
                steady_left--;
                gap_left = 0;
            end else if (gap_roll < 3) begin
                steady_left = $urandom_range(20, 60);
                gap_left = 0;
            end else if (gap_roll < 60) begin
                gap_left = 0;
            end else if (gap_roll < 92) begin
                gap_left = $urandom_range(1, 4);
            end else begin
                gap_left = $urandom_range(10, 60);
            end
        end
        if (i_rst_n && pending_items.size() != 0 && gap_left == 0) begin
            start <= 1'b1;
            i_item <= pending_items[0];
        end else begin
            start <= 1'b0;
            if (gap_left != 0) gap_left--;
        end
    end

    // Check each result beat against the oldest expected pose
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (expected_poses.size() == 0) begin
                report_mismatch("unexpected beat, status", 32'(o_res.status), '0);
            end else begin
                want_res = expected_poses.pop_front();
                checked_count++;
                if (want_res.status == STAT_PAST) past_seen++;
                if (o_res.out_x !== want_res.out_x)
                    report_mismatch("out_x", o_res.out_x, want_res.out_x);
                if (o_res.out_y !== want_res.out_y)
                    report_mismatch("out_y", o_res.out_y, want_res.out_y);
                if (o_res.out_z !== want_res.out_z)
                    report_mismatch("out_z", o_res.out_z, want_res.out_z);
                if (o_res.status !== want_res.status)
                    report_mismatch("status", 32'(o_res.status), 32'(want_res.status));
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d poses outstanding", expected_poses.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int          n;
        int          kind;
        int          slot;
        int          scale;
        logic [31:0] lo;
        logic [31:0] hi;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single key at reset: the key's own value comes back
        queue_load(0, 32'h0001_0000, Q_MAX, Q_MIN, 32'h0001_0000);
        queue_sample(32'h0000_0000);
        wait_idle();
        apb_write(REG_KEYS, 32'd0);
        queue_sample($urandom);

        // four keys with extreme values
        wait_idle();
        apb_write(REG_KEYS, 32'd4);
        queue_load(1, 32'h0002_0000, Q_MIN, Q_MAX, 32'hFFFF_0000);
        queue_load(2, 32'h0004_0000, 32'h0, 32'h0000_8000, Q_MAX);
        queue_load(3, 32'h0004_8000, 32'hFFFF_FFFF, 32'h0, Q_MIN);
        queue_sample(32'h0000_0000);
        queue_sample(32'h0001_0000);
        queue_sample(32'h0001_8000);
        queue_sample(32'h0002_0000);
        queue_sample(32'h0004_7FFF);
        queue_sample(32'h0004_8000);
        queue_sample(32'hFFFF_FFFF);

        // clamped factor: no extrapolation before the first key
        wait_idle();
        apb_write(REG_CLAMP, 32'd1);
        queue_sample(32'h0000_0000);
        queue_sample(32'h0003_0000);

        // factor saturation across a one-tick segment at the top of time
        wait_idle();
        apb_write(REG_CLAMP, 32'd0);
        apb_write(REG_KEYS, 32'd2);
        queue_load(0, 32'hFFFF_FFFE, Q_MAX, Q_MIN, 32'h0000_0001);
        queue_load(1, 32'hFFFF_FFFF, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
        queue_sample(32'h0000_0000);
        queue_sample(32'hFFFF_FFFE);

        // descending keys: the start key's value before the end key's time, else past the last key
        queue_load(0, 32'h0005_0000, 32'h0012_3456, Q_MIN, 32'h0000_0000);
        queue_load(1, 32'h0003_0000, 32'h0000_0001, Q_MAX, 32'h7654_3210);
        queue_sample(32'h0001_0000);
        queue_sample(32'h0004_0000);

        // random phases over several register settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            apb_write(REG_KEYS, 32'(phase_keys[p]));
            apb_write(REG_CLAMP, 32'(phase_clamp[p]));
            n = keys_active();
            case ($urandom_range(0, 3))
                0: scale = 8;
                1: scale = 16;
                2: scale = 24;
                default: scale = 27;
            endcase
            fill_track(n, scale);
            repeat (PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    queue_sample(pick_query(n));
                end else if (kind < 92 && n >= 3) begin
                    // move an inner key while keeping the track in order
                    slot = $urandom_range(1, n - 2);
                    lo = plan_time[slot - 1];
                    hi = plan_time[slot + 1];
                    queue_load(slot, (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo,
                               rand_value(), rand_value(), rand_value());
                end else begin
                    queue_load($urandom_range(0, MAX_KEYS - 1), $urandom,
                               rand_value(), rand_value(), rand_value());
                end
            end
        end

        wait_idle();
        repeat (80) @(posedge i_clk);
        if (expected_poses.size() != 0)
            report_mismatch("poses never returned", 32'(expected_poses.size()), '0);

        $display("covered %0d loads and %0d samples (%0d clamped, %0d past the last key)",
                 loads_taken, samples_taken, clamped_samples, past_seen);
        $display("checked %0d result beats over %0d register settings, %0d mismatches",
                 checked_count, PHASES + 5, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[keyframe_vec3_sampler.f]
rtl/kvs_pkg.sv
rtl/kvs_ram.sv
rtl/keyframe_vec3_sampler.sv
dv/keyframe_vec3_sampler_tb.sv
